// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  // Width of the key and tag fields on the stream words
  localparam int unsigned FIELD_W = 16;
  // Width of the fill count field on the result word
  localparam int unsigned FILL_W  = 5;
  // Packed widths of the input and result words (whole bytes)
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 40;

  // Action codes of an input word
  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2
  } action_t;

  // Status codes of a result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states: result register empty or holding a word
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_HOLD = 1'b1
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;       // capture a result word this cycle
    logic    push;       // insert the incoming entry
    logic    pop;        // remove the head entry
    logic    give_head;  // result carries the head entry
    status_t status;     // status code of the result
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller: handshakes, action decode and command generation.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  output logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);

  spq_pkg::ctrl_state_t state, state_next;
  logic accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshakes and commands
  always_comb begin
    in_ready  = (state == spq_pkg::CS_IDLE) || out_ready;
    out_valid = (state == spq_pkg::CS_HOLD);
    accept    = in_valid && in_ready;

    state_next = state;
    if (accept) begin
      state_next = spq_pkg::CS_HOLD;
    end else if (out_ready) begin
      state_next = spq_pkg::CS_IDLE;
    end

    cmd           = '0;
    cmd.status    = spq_pkg::ST_OK;
    cmd.load      = accept;
    unique case (spq_pkg::action_t'(action))
      spq_pkg::ACT_PUSH: begin
        if (stat.full) begin
          cmd.status = spq_pkg::ST_FULL;
        end else begin
          cmd.push = accept;
        end
      end
      spq_pkg::ACT_POP: begin
        if (stat.empty) begin
          cmd.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.pop       = accept;
          cmd.give_head = 1'b1;
        end
      end
      spq_pkg::ACT_PEEK: begin
        if (stat.empty) begin
          cmd.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.give_head = 1'b1;
        end
      end
      // unused code: no change, plain ok result
      default: begin
        cmd.status = spq_pkg::ST_OK;
      end
    endcase
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full) else $error("push issued into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty) else $error("pop issued on empty queue");
  a_load_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid) else $error("accepted word left no result");

endmodule

// ===== rtl/spq_datapath.sv =====
// Datapath: row of sorted entry cells, fill count and result register.
module spq_datapath #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [spq_pkg::FIELD_W-1:0]  in_key,
  input  logic [spq_pkg::FIELD_W-1:0]  in_tag,
  input  spq_pkg::dp_cmd_t             cmd,
  output spq_pkg::dp_stat_t            stat,
  output logic [spq_pkg::OUT_W-1:0]    result
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Entry cells, head at cell zero, ascending keys
  logic [KEY_BITS-1:0] cell_key      [DEPTH];
  logic [TAG_BITS-1:0] cell_tag      [DEPTH];
  logic [KEY_BITS-1:0] cell_key_next [DEPTH];
  logic [TAG_BITS-1:0] cell_tag_next [DEPTH];
  logic [DEPTH-1:0]    ge;
  logic [CNT_W-1:0]    count, count_next;
  logic [KEY_BITS-1:0] new_key;
  logic [TAG_BITS-1:0] new_tag;

  // Result register fields
  spq_pkg::status_t            res_status;
  logic [spq_pkg::FIELD_W-1:0] res_key;
  logic [spq_pkg::FIELD_W-1:0] res_tag;
  logic [spq_pkg::FILL_W-1:0]  res_fill;
  logic                        res_empty;

  assign new_key = KEY_BITS'(in_key);
  assign new_tag = TAG_BITS'(in_tag);

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Per-cell compare: stored entry not smaller than the incoming key
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (count > CNT_W'(i)) && (cell_key[i] >= new_key);
    end
  end

  // Per-cell next value: shift right on push, shift left on pop
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_key_next[i] = cell_key[i];
      cell_tag_next[i] = cell_tag[i];
      if (cmd.push) begin
        if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
          cell_key_next[i] = cell_key[(i > 0) ? i - 1 : 0];
          cell_tag_next[i] = cell_tag[(i > 0) ? i - 1 : 0];
        end else if (ge[i] || (count == CNT_W'(i))) begin
          cell_key_next[i] = new_key;
          cell_tag_next[i] = new_tag;
        end
      end else if (cmd.pop && (i < DEPTH - 1)) begin
        cell_key_next[i] = cell_key[(i < DEPTH - 1) ? i + 1 : i];
        cell_tag_next[i] = cell_tag[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Fill count after this operation
  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  // Entry cells hold payload only, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_key[i] <= cell_key_next[i];
      cell_tag[i] <= cell_tag_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= cmd.status;
      res_key    <= cmd.give_head ? spq_pkg::FIELD_W'(cell_key[0]) : '0;
      res_tag    <= cmd.give_head ? spq_pkg::FIELD_W'(cell_tag[0]) : '0;
      res_fill   <= spq_pkg::FILL_W'(count_next);
      res_empty  <= (count_next == '0);
    end
  end

  assign result = {res_empty, res_fill, res_tag, res_key, res_status};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("fill count beyond depth");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> count == CNT_W'($past(count) + 1'b1))
    else $error("push did not raise the fill count");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == CNT_W'($past(count) - 1'b1))
    else $error("pop did not lower the fill count");

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: controller plus cell datapath.
//
//  channel  | dir | tdata fields, lowest bit up
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | action[1:0] in_key[17:2] in_tag[33:18] zero[39:34]
//  m_axis   | out | status[1:0] out_key[17:2] out_tag[33:18] fill_count[38:34]
//           |     | is_empty[39]
//
// Every cell compares against the incoming key in parallel and the row shifts in
// the same edge, so the rate is one word a cycle while m_axis takes each result.
// The result appears in an output register in the cycle after acceptance, and a
// new word is taken in the cycle the held result leaves.
// Reset clears the fill count and the controller state; entry cells and the
// result register are not reset, m_axis_tvalid stays low until a word is taken.
// A stalled m_axis holds the result and stops s_axis until it is taken.
module sorted_priority_queue_unit #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [spq_pkg::IN_W-1:0]   s_axis_tdata,   // action, in_key, in_tag
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [spq_pkg::OUT_W-1:0]  m_axis_tdata    // status, out_key, out_tag,
                                                     // fill_count, is_empty
);

  spq_pkg::dp_cmd_t  cmd;
  spq_pkg::dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .action    (s_axis_tdata[1:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_key (s_axis_tdata[17:2]),
    .in_tag (s_axis_tdata[33:18]),
    .cmd    (cmd),
    .stat   (stat),
    .result (m_axis_tdata)
  );

endmodule

// ===== tb/sv/sorted_priority_queue_unit_tb.sv =====
// Self-checking testbench for the sorted priority queue unit: shadow queue, driver, checker.
module sorted_priority_queue_unit_tb;

  localparam int unsigned QDEPTH      = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  // action code the block leaves unused: no-op that still reports the fill
  localparam logic [1:0]  ACT_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0]                 status;
    logic [15:0]                key;
    logic [15:0]                tag;
    logic [spq_pkg::FILL_W-1:0] fill;
    logic                       empty;
  } result_word_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [spq_pkg::IN_W-1:0]  s_axis_tdata = '0;  // action, in_key, in_tag, zero pad
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [spq_pkg::OUT_W-1:0] m_axis_tdata;       // status, out_key, out_tag, fill, empty

  // shadow of the queue contents
  logic [15:0]       shadow_keys [QDEPTH];
  logic [15:0]       shadow_tags [QDEPTH];
  int unsigned       shadow_fill = 0;
  result_word_t      pending_results [$];

  int unsigned       errors = 0;
  int unsigned       words_sent = 0;
  int unsigned       words_checked = 0;
  int unsigned       full_drops = 0;
  int unsigned       empty_reads = 0;
  int unsigned       peak_fill = 0;
  int unsigned       input_stall_cycles = 0;
  int unsigned       cycles = 0;
  int unsigned       rx_hold_left = 0;
  int unsigned       hold_requests = 0;
  int unsigned       hold_served = 0;
  bit                idle_en = 1'b1;
  bit                filling = 1'b1;

  sorted_priority_queue_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow queue and return the word it should give
  function automatic result_word_t queue_apply(input logic [1:0] act, input logic [15:0] key,
                                               input logic [15:0] tag);
    result_word_t r;
    int unsigned  pos;
    int unsigned  i;
    r = '0;
    r.status = spq_pkg::ST_OK;
    case (act)
      spq_pkg::ACT_PUSH: begin
        if (shadow_fill >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
          full_drops++;
        end else begin
          // new entry goes ahead of every stored entry with an equal key
          pos = shadow_fill;
          while (pos > 0 && !(shadow_keys[pos-1] < key)) begin
            shadow_keys[pos] = shadow_keys[pos-1];
            shadow_tags[pos] = shadow_tags[pos-1];
            pos--;
          end
          shadow_keys[pos] = key;
          shadow_tags[pos] = tag;
          shadow_fill++;
        end
      end
      spq_pkg::ACT_POP, spq_pkg::ACT_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          empty_reads++;
        end else begin
          r.key = shadow_keys[0];
          r.tag = shadow_tags[0];
          if (act == spq_pkg::ACT_POP) begin
            for (i = 1; i < shadow_fill; i++) begin
              shadow_keys[i-1] = shadow_keys[i];
              shadow_tags[i-1] = shadow_tags[i];
            end
            shadow_fill--;
          end
        end
      end
      default: ;
    endcase
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    r.fill  = shadow_fill[spq_pkg::FILL_W-1:0];
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $display("MISMATCH word %0d %s: expected 0x%0h got 0x%0h", words_checked, field, want, got);
    errors++;
  endtask

  // Offer one word and wait for it to be taken; idles at random first
  task automatic send_word(input logic [1:0] act, input logic [15:0] key,
                           input logic [15:0] tag);
    while (idle_en && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, tag, key, act};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(queue_apply(act, key, tag));
    words_sent++;
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Random operation, biased to sweep the fill between empty and full
  task automatic send_random_op();
    logic [1:0]  act;
    logic [15:0] key;
    int unsigned r;
    if (shadow_fill == QDEPTH) filling = 1'b0;
    else if (shadow_fill == 0) filling = 1'b1;
    else if ($urandom_range(99) < 2) filling = ~filling;
    r = $urandom_range(99);
    if (r < 3)                          act = ACT_NOP;
    else if (r < 13)                    act = spq_pkg::ACT_PEEK;
    else if (r < (filling ? 78 : 38))   act = spq_pkg::ACT_PUSH;
    else                                act = spq_pkg::ACT_POP;
    // small keys give many ties, extremes hit the compare edges
    case ($urandom_range(3))
      0:       key = 16'($urandom_range(7));
      1:       key = ($urandom_range(1) != 0) ? 16'hFFFF - 16'($urandom_range(1))
                                              : 16'($urandom_range(1));
      default: key = 16'($urandom);
    endcase
    send_word(act, key, 16'($urandom));
  endtask

  // Extremes, every action, empty and full cases, equal-key ordering
  task automatic test_directed();
    int unsigned i;
    send_word(spq_pkg::ACT_PEEK, 16'h0000, 16'h0000);
    send_word(spq_pkg::ACT_POP,  16'hFFFF, 16'hFFFF);
    send_word(ACT_NOP,           16'h1234, 16'h5678);
    send_word(spq_pkg::ACT_PUSH, 16'h0000, 16'hFFFF);
    send_word(spq_pkg::ACT_PUSH, 16'hFFFF, 16'h0000);
    send_word(spq_pkg::ACT_PUSH, 16'h8000, 16'hAAAA);
    send_word(spq_pkg::ACT_PUSH, 16'h8000, 16'h5555);
    send_word(spq_pkg::ACT_PEEK, 16'hFFFF, 16'hFFFF);
    send_word(ACT_NOP,           16'hFFFF, 16'hFFFF);
    for (i = 0; i < 12; i++)
      send_word(spq_pkg::ACT_PUSH, 16'($urandom), 16'($urandom));
    send_word(spq_pkg::ACT_PUSH, 16'h0001, 16'hBEEF);   // queue full: dropped
    send_word(spq_pkg::ACT_POP,  16'h0000, 16'h0000);
    send_word(spq_pkg::ACT_POP,  16'h0000, 16'h0000);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_random_op();
  endtask

  // Back-to-back words with neither side idling
  task automatic test_no_idle(input int unsigned count);
    idle_en = 1'b0;
    repeat (count) send_random_op();
    idle_en = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, so input backs up
  task automatic test_output_hold();
    hold_requests++;
    repeat (40) send_random_op();
  endtask

  // Short bursts, each followed by a pause until the queue has answered all
  task automatic test_burst_and_drain(input int unsigned bursts);
    repeat (bursts) begin
      repeat ($urandom_range(20, 4)) send_random_op();
      wait_results_drained();
    end
  endtask

  // Result side: check each accepted word
  always @(posedge clk) begin
    result_word_t got;
    result_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tdata[33:18],
             m_axis_tdata[38:34], m_axis_tdata[39]};
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word", 32'd0, 32'(m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.key !== want.key)
          flag_mismatch("out_key", 32'(want.key), 32'(got.key));
        if (got.tag !== want.tag)
          flag_mismatch("out_tag", 32'(want.tag), 32'(got.tag));
        if (got.fill !== want.fill)
          flag_mismatch("fill_count", 32'(want.fill), 32'(got.fill));
        if (got.empty !== want.empty)
          flag_mismatch("is_empty", 32'(want.empty), 32'(got.empty));
      end
      words_checked++;
    end
  end

  // Receiver ready: a long hold when one is requested, else random idling when enabled
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served  = hold_requests;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= !(idle_en && $urandom_range(99) < 13);
    end
  end

  // Cycle count, input stall count and timeout
  always @(posedge clk) begin
    cycles++;
    if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(700);
    test_no_idle(400);
    test_output_hold();
    test_random_traffic(500);
    test_burst_and_drain(30);
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("words never returned", 32'd0, 32'(pending_results.size()));
    $display("covered %0d words, %0d results checked, %0d pushes dropped on full",
             words_sent, words_checked, full_drops);
    $display("%0d empty reads, peak fill %0d, input held back for %0d cycles",
             empty_reads, peak_fill, input_stall_cycles);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue_unit.sv
tb/sv/sorted_priority_queue_unit_tb.sv
